FILE: src/srcl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the scan range clustering block.
// No dependencies; imported by srcl_ctrl, srcl_dpath and the top module.
package srcl_pkg;

    localparam int DEF_SCAN_POINTS = 512;
    localparam int CFG_W = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int SIZE_W = 10;           // width of min/max point registers
    localparam int RANGE_W = 16;
    localparam int CENT_W = 17;
    localparam int COORD_W = 18;          // internal point coordinate, signed
    localparam int CORDIC_STAGES = 16;
    localparam int CX_W = 36;             // CORDIC x/y datapath width
    localparam int CZ_W = 26;             // CORDIC angle width, 1/2^24 turn
    localparam int SQ_W = 36;
    localparam int D2_W = 37;
    localparam logic [15:0] CORDIC_GAIN_Q16 = 16'd39797;
    localparam int COORD_MAX = 65535;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_ANGLE_STEP = 2'd1,
        CFG_MIN_POINTS = 2'd2,
        CFG_MAX_POINTS = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        SQ_DX = 3'd0,
        SQ_DY = 3'd1,
        SQ_FX = 3'd2,
        SQ_FY = 3'd3,
        SQ_THR = 3'd4
    } sq_sel_t;

    typedef struct packed {
        logic       accept;
        logic       angle;
        logic       init;
        logic       rotate;
        logic [3:0] iter;
        logic       round;
        logic       square;
        sq_sel_t    sq_sel;
        logic       sum;
        logic       update;
        logic       take;
        logic       load;
    } cmd_t;

    typedef struct packed {
        logic pending;
        logic div_busy;
        logic out_free;
    } status_t;

    function automatic logic [21:0] atan_lut(input logic [3:0] i);
        logic [21:0] v;
        unique case (i)
            4'd0: v = 22'd2097152;
            4'd1: v = 22'd1238021;
            4'd2: v = 22'd654136;
            4'd3: v = 22'd332051;
            4'd4: v = 22'd166669;
            4'd5: v = 22'd83416;
            4'd6: v = 22'd41718;
            4'd7: v = 22'd20860;
            4'd8: v = 22'd10430;
            4'd9: v = 22'd5215;
            4'd10: v = 22'd2608;
            4'd11: v = 22'd1304;
            4'd12: v = 22'd652;
            4'd13: v = 22'd326;
            4'd14: v = 22'd163;
            4'd15: v = 22'd81;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: src/srcl_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by srcl_dpath for centroid division.
module srcl_div #(
    parameter int NUM_W = 27,
    parameter int DEN_W = 10
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  busy,
    output logic [NUM_W-1:0]      quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W:0]   rem_reg, rem_next;
    logic [NUM_W-1:0] acc_reg, acc_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W:0]   shifted;
    logic             qbit;

    always_comb
    begin
        shifted = {rem_reg[DEN_W-1:0], acc_reg[NUM_W-1]};
        qbit = (shifted >= {1'b0, den_reg});
        rem_next = qbit ? shifted - {1'b0, den_reg} : shifted;
        acc_next = {acc_reg[NUM_W-2:0], qbit};
        cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            acc_reg <= num;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            acc_reg <= acc_next;
        end
    end

    assign busy = (cnt_reg != '0);
    assign quo = acc_reg;

endmodule
`default_nettype wire

FILE: src/srcl_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// Datapath: point conversion, gap test, cluster sums, result queue, output register.
// Depends on srcl_pkg and srcl_div; driven by srcl_ctrl commands.
module srcl_dpath import srcl_pkg::*; #(
    parameter int SCAN_POINTS = DEF_SCAN_POINTS,
    localparam int IDX_W = $clog2(SCAN_POINTS),
    localparam int CNT_W = $clog2(SCAN_POINTS + 1)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output status_t                 status,
    input  wire logic [RANGE_W-1:0] range_mm,
    input  wire logic               last_sample,
    input  wire logic               cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]   cfg_wdata,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [CENT_W-1:0] centroid_x,
    output logic signed [CENT_W-1:0] centroid_y,
    output logic [CNT_W-1:0]        point_count,
    output logic [IDX_W-1:0]        start_index,
    output logic                    last_of_run
);
    localparam int SUM_W = IDX_W + 18;
    localparam int CMP_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
    localparam int NREC = 3;

    typedef struct packed {
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
        logic [CNT_W-1:0]        cnt;
        logic [IDX_W-1:0]        start;
    } rec_t;

    // configuration
    logic [CFG_W-1:0]  thr_reg, step_reg;
    logic [SIZE_W-1:0] min_reg, max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 16'd100;
            step_reg <= 16'd182;
            min_reg <= 10'd4;
            max_reg <= 10'd25;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_THRESHOLD: thr_reg <= cfg_wdata;
                CFG_ANGLE_STEP: step_reg <= cfg_wdata;
                CFG_MIN_POINTS: min_reg <= cfg_wdata[SIZE_W-1:0];
                CFG_MAX_POINTS: max_reg <= cfg_wdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // input beat and angle
    logic [RANGE_W-1:0] r_reg;
    logic               last_reg;
    logic [15:0]        ang_reg;
    logic [31:0]        mag_reg;
    logic               flip_reg;
    logic signed [CX_W-1:0] x_reg, y_reg;
    logic signed [CZ_W-1:0] z_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg;

    // scan state
    logic [IDX_W-1:0] idx_reg;
    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg, fx_reg, fy_reg;
    logic signed [SUM_W-1:0] cur_sx_reg, cur_sy_reg, held_sx_reg, held_sy_reg;
    logic [CNT_W-1:0] cur_cnt_reg, held_cnt_reg;
    logic [IDX_W-1:0] cur_start_reg;
    logic             held_valid_reg;

    logic [SQ_W-1:0] sq_reg [5];
    logic [D2_W-1:0] d2p_reg, d2f_reg, thr2_reg;

    logic signed [16:0] t_ang;
    logic               flip;
    logic signed [CX_W-1:0] dx_c, dy_c, xr, yr;
    logic signed [CZ_W-1:0] atan_c;
    logic signed [COORD_W:0] sq_op;
    logic signed [2*COORD_W+1:0] sq_prod;

    always_comb
    begin
        flip = (ang_reg[15:14] == 2'b01) || (ang_reg[15:14] == 2'b10);
        if (flip)
            t_ang = $signed({1'b0, ang_reg}) - 17'sd32768;
        else
            t_ang = $signed({ang_reg[15], ang_reg});
        dx_c = y_reg >>> cmd.iter;
        dy_c = x_reg >>> cmd.iter;
        atan_c = $signed(CZ_W'(atan_lut(cmd.iter)));
        xr = (x_reg + CX_W'(32768)) >>> 16;
        yr = (y_reg + CX_W'(32768)) >>> 16;
        if (flip_reg)
        begin
            xr = -xr;
            yr = -yr;
        end
        unique case (cmd.sq_sel)
            SQ_DX: sq_op = (COORD_W+1)'(prev_x_reg) - (COORD_W+1)'(px_reg);
            SQ_DY: sq_op = (COORD_W+1)'(prev_y_reg) - (COORD_W+1)'(py_reg);
            SQ_FX: sq_op = (COORD_W+1)'(px_reg) - (COORD_W+1)'(fx_reg);
            SQ_FY: sq_op = (COORD_W+1)'(py_reg) - (COORD_W+1)'(fy_reg);
            SQ_THR: sq_op = $signed({3'b000, thr_reg});
            default: sq_op = '0;
        endcase
        sq_prod = sq_op * sq_op;
    end

    function automatic logic signed [COORD_W-1:0] clamp(input logic signed [CX_W-1:0] v);
        if (v > CX_W'(COORD_MAX))
            return COORD_W'(COORD_MAX);
        else if (v < -CX_W'(COORD_MAX))
            return -COORD_W'(COORD_MAX);
        else
            return COORD_W'(v);
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            r_reg <= range_mm;
        end
        if (cmd.angle)
        begin
            ang_reg <= 16'(idx_reg * step_reg);
            mag_reg <= r_reg * CORDIC_GAIN_Q16;
        end
        if (cmd.init)
        begin
            flip_reg <= flip;
            x_reg <= CX_W'(mag_reg);
            y_reg <= '0;
            z_reg <= CZ_W'(t_ang) <<< 8;
        end
        if (cmd.rotate)
        begin
            if (!z_reg[CZ_W-1])
            begin
                x_reg <= x_reg - dx_c;
                y_reg <= y_reg + dy_c;
                z_reg <= z_reg - atan_c;
            end
            else
            begin
                x_reg <= x_reg + dx_c;
                y_reg <= y_reg - dy_c;
                z_reg <= z_reg + atan_c;
            end
        end
        if (cmd.round)
        begin
            px_reg <= clamp(xr);
            py_reg <= clamp(yr);
        end
        if (cmd.square)
        begin
            sq_reg[cmd.sq_sel] <= SQ_W'(sq_prod);
        end
        if (cmd.sum)
        begin
            d2p_reg <= D2_W'(sq_reg[SQ_DX]) + D2_W'(sq_reg[SQ_DY]);
            d2f_reg <= D2_W'(sq_reg[SQ_FX]) + D2_W'(sq_reg[SQ_FY]);
            thr2_reg <= D2_W'(sq_reg[SQ_THR]);
        end
    end

    // cluster update
    logic idx0, brk, hv1, merge;
    logic signed [SUM_W-1:0] hsx1, hsy1, csx1, csy1;
    logic [CNT_W-1:0] hcnt1, ccnt1;
    logic [IDX_W-1:0] cstart1;
    rec_t rec_c [NREC];
    logic [NREC-1:0] rv_c;

    function automatic logic passes(input logic [CNT_W-1:0] n,
                                    input logic [SIZE_W-1:0] lo,
                                    input logic [SIZE_W-1:0] hi);
        return (n != '0) && (CMP_W'(n) >= CMP_W'(lo)) && (CMP_W'(n) < CMP_W'(hi));
    endfunction

    always_comb
    begin
        idx0 = (idx_reg == '0);
        brk = !idx0 && (d2p_reg >= thr2_reg);
        hv1 = idx0 ? 1'b0 : (held_valid_reg || brk);
        if (idx0)
        begin
            hsx1 = '0;
            hsy1 = '0;
            hcnt1 = '0;
        end
        else if (brk && !held_valid_reg)
        begin
            hsx1 = cur_sx_reg;
            hsy1 = cur_sy_reg;
            hcnt1 = cur_cnt_reg;
        end
        else
        begin
            hsx1 = held_sx_reg;
            hsy1 = held_sy_reg;
            hcnt1 = held_cnt_reg;
        end
        if (idx0 || brk)
        begin
            csx1 = SUM_W'(px_reg);
            csy1 = SUM_W'(py_reg);
            ccnt1 = CNT_W'(1);
            cstart1 = idx_reg;
        end
        else
        begin
            csx1 = cur_sx_reg + SUM_W'(px_reg);
            csy1 = cur_sy_reg + SUM_W'(py_reg);
            ccnt1 = cur_cnt_reg + CNT_W'(1);
            cstart1 = cur_start_reg;
        end
        merge = last_reg && hv1 && (d2f_reg < thr2_reg);

        rec_c[0] = '{sx: cur_sx_reg, sy: cur_sy_reg, cnt: cur_cnt_reg, start: cur_start_reg};
        rv_c[0] = brk && held_valid_reg;
        if (merge)
            rec_c[1] = '{sx: hsx1 + csx1, sy: hsy1 + csy1, cnt: hcnt1 + ccnt1,
                         start: cstart1};
        else
            rec_c[1] = '{sx: hsx1, sy: hsy1, cnt: hcnt1, start: '0};
        rv_c[1] = last_reg && hv1;
        rec_c[2] = '{sx: csx1, sy: csy1, cnt: ccnt1, start: cstart1};
        rv_c[2] = last_reg && !merge;
        for (int i = 0; i < NREC; i++)
        begin
            rv_c[i] = rv_c[i] && passes(rec_c[i].cnt, min_reg, max_reg);
        end
    end

    rec_t rec_reg [NREC];
    logic [NREC-1:0] rv_reg;
    logic [1:0] pick;

    always_comb
    begin
        priority if (rv_reg[0])
            pick = 2'd0;
        else if (rv_reg[1])
            pick = 2'd1;
        else
            pick = 2'd2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            held_valid_reg <= 1'b0;
            rv_reg <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                last_reg <= last_sample || (idx_reg == IDX_W'(SCAN_POINTS - 1));
            end
            if (cmd.update)
            begin
                idx_reg <= last_reg ? '0 : idx_reg + IDX_W'(1);
                held_valid_reg <= last_reg ? 1'b0 : hv1;
                rv_reg <= rv_c;
            end
            else if (cmd.take)
            begin
                rv_reg[pick] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            prev_x_reg <= px_reg;
            prev_y_reg <= py_reg;
            if (idx0)
            begin
                fx_reg <= px_reg;
                fy_reg <= py_reg;
            end
            held_sx_reg <= hsx1;
            held_sy_reg <= hsy1;
            held_cnt_reg <= hcnt1;
            cur_sx_reg <= csx1;
            cur_sy_reg <= csy1;
            cur_cnt_reg <= ccnt1;
            cur_start_reg <= cstart1;
            for (int i = 0; i < NREC; i++)
            begin
                rec_reg[i] <= rec_c[i];
            end
        end
    end

    // centroid division: magnitude plus half count, then sign restored
    logic [SUM_W-1:0] num_x, num_y, qx, qy;
    logic busy_x, busy_y;
    logic neg_x_reg, neg_y_reg, olast_reg;
    logic [CNT_W-1:0] ocnt_reg;
    logic [IDX_W-1:0] ostart_reg;
    rec_t sel;

    always_comb
    begin
        sel = rec_reg[pick];
        num_x = (sel.sx[SUM_W-1] ? SUM_W'(-sel.sx) : SUM_W'(sel.sx))
                + SUM_W'(sel.cnt >> 1);
        num_y = (sel.sy[SUM_W-1] ? SUM_W'(-sel.sy) : SUM_W'(sel.sy))
                + SUM_W'(sel.cnt >> 1);
    end

    srcl_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div_x (
        .clk(clk), .rst_n(rst_n), .start(cmd.take), .num(num_x),
        .den(sel.cnt), .busy(busy_x), .quo(qx)
    );
    srcl_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div_y (
        .clk(clk), .rst_n(rst_n), .start(cmd.take), .num(num_y),
        .den(sel.cnt), .busy(busy_y), .quo(qy)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            neg_x_reg <= sel.sx[SUM_W-1];
            neg_y_reg <= sel.sy[SUM_W-1];
            ocnt_reg <= sel.cnt;
            ostart_reg <= sel.start;
            olast_reg <= ((rv_reg >> (pick + 2'd1)) == '0);
        end
        if (cmd.load)
        begin
            centroid_x <= neg_x_reg ? -$signed(CENT_W'(qx)) : $signed(CENT_W'(qx));
            centroid_y <= neg_y_reg ? -$signed(CENT_W'(qy)) : $signed(CENT_W'(qy));
            point_count <= ocnt_reg;
            start_index <= ostart_reg;
            last_of_run <= olast_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.load)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    assign status.pending = |rv_reg;
    assign status.div_busy = busy_x || busy_y;
    assign status.out_free = !out_valid || out_ready;

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> !(busy_x || busy_y))
        else $error("divider restarted while busy");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!out_valid || out_ready))
        else $error("output register overwritten");
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> (rv_reg == '0))
        else $error("new beat accepted with results queued");
    a_div_pair: assert property (@(posedge clk) disable iff (!rst_n)
        busy_x == busy_y)
        else $error("centroid dividers out of step");

endmodule
`default_nettype wire

FILE: src/srcl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// Controller state machine sequencing one sample through the datapath.
// Depends on srcl_pkg; commands srcl_dpath.
module srcl_ctrl import srcl_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output cmd_t         cmd,
    input  wire status_t status
);
    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_ANGLE  = 11'b00000000010,
        S_INIT   = 11'b00000000100,
        S_ROTATE = 11'b00000001000,
        S_ROUND  = 11'b00000010000,
        S_SQUARE = 11'b00000100000,
        S_SUM    = 11'b00001000000,
        S_UPDATE = 11'b00010000000,
        S_PICK   = 11'b00100000000,
        S_DIVIDE = 11'b01000000000,
        S_OUTPUT = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic [3:0] iter_reg, iter_next;
    sq_sel_t sq_reg, sq_next;

    always_comb
    begin
        state_next = state_reg;
        iter_next = iter_reg;
        sq_next = sq_reg;
        cmd = '0;
        cmd.iter = iter_reg;
        cmd.sq_sel = sq_reg;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_ANGLE;
                end
            end
            S_ANGLE:
            begin
                cmd.angle = 1'b1;
                state_next = S_INIT;
            end
            S_INIT:
            begin
                cmd.init = 1'b1;
                iter_next = '0;
                state_next = S_ROTATE;
            end
            S_ROTATE:
            begin
                cmd.rotate = 1'b1;
                iter_next = iter_reg + 4'd1;
                if (iter_reg == 4'(CORDIC_STAGES - 1))
                    state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                sq_next = SQ_DX;
                state_next = S_SQUARE;
            end
            S_SQUARE:
            begin
                cmd.square = 1'b1;
                unique case (sq_reg)
                    SQ_DX: sq_next = SQ_DY;
                    SQ_DY: sq_next = SQ_FX;
                    SQ_FX: sq_next = SQ_FY;
                    SQ_FY: sq_next = SQ_THR;
                    default:
                    begin
                        sq_next = SQ_DX;
                        state_next = S_SUM;
                    end
                endcase
            end
            S_SUM:
            begin
                cmd.sum = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_PICK;
            end
            S_PICK:
            begin
                if (status.pending)
                begin
                    cmd.take = 1'b1;
                    state_next = S_DIVIDE;
                end
                else
                    state_next = S_IDLE;
            end
            S_DIVIDE:
            begin
                if (!status.div_busy)
                    state_next = S_OUTPUT;
            end
            S_OUTPUT:
            begin
                if (status.out_free)
                begin
                    cmd.load = 1'b1;
                    state_next = S_PICK;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            iter_reg <= '0;
            sq_reg <= SQ_DX;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg <= iter_next;
            sq_reg <= sq_next;
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.angle, cmd.init, cmd.rotate, cmd.round, cmd.square,
                  cmd.sum, cmd.update, cmd.take, cmd.load}))
        else $error("more than one datapath command");
    a_rotate_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.init |=> ##15 (state_reg == S_ROTATE && iter_reg == 4'd15))
        else $error("rotation ran short");
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg == S_ANGLE)
        else $error("accept did not start conversion");

endmodule
`default_nettype wire

FILE: src/scan_range_clustering_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Lidar scan clustering: range beat in, cluster centroid beats out.
// Per beat: angle, CORDIC rotation, rounding, squaring and cluster update,
// then a serial centroid division for each reported cluster.
// A beat with no result then frees the input; up to 3 results per beat.
// The output register lets the next beat enter while a result waits.
// rst_n is asynchronous, active low; control, valid and configuration registers reset, data registers do not.
module scan_range_clustering_top import srcl_pkg::*; #(
    parameter int SCAN_POINTS = DEF_SCAN_POINTS,
    localparam int IDX_W = $clog2(SCAN_POINTS),
    localparam int CNT_W = $clog2(SCAN_POINTS + 1),
    localparam int OUT_BITS = 2 * CENT_W + CNT_W + IDX_W,
    localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [RANGE_W-1:0]    s_axis_tdata,   // range_mm
    input  wire logic                  s_axis_tlast,   // last_sample
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // centroid_x, centroid_y, point_count, start_index, zero pad
    output logic [M_TDATA_W-1:0]       m_axis_tdata,
    output logic                       m_axis_tlast,   // last_of_run
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wdata
);
    cmd_t    cmd;
    status_t status;
    logic signed [CENT_W-1:0] cx, cy;
    logic [CNT_W-1:0] cnt;
    logic [IDX_W-1:0] start;

    srcl_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready), .cmd(cmd), .status(status)
    );

    srcl_dpath #(.SCAN_POINTS(SCAN_POINTS)) u_dpath (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .range_mm(s_axis_tdata), .last_sample(s_axis_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .centroid_x(cx), .centroid_y(cy), .point_count(cnt),
        .start_index(start), .last_of_run(m_axis_tlast)
    );

    assign m_axis_tdata = M_TDATA_W'({start, cnt, cy, cx});

endmodule
`default_nettype wire
